[design/aes_sb_pkg.sv]
// Package with GF(2^8) arithmetic and affine maps for the AES byte substitution.
package aes_sb_pkg;

    // Low byte of the reduction polynomial x^8+x^4+x^3+x+1
    localparam logic [7:0] POLY_LOW  = 8'h1B;
    localparam logic [7:0] FWD_CONST = 8'h63;
    localparam logic [7:0] INV_CONST = 8'h05;

    // Direction codes carried on tuser
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_INV = 1'b1;

    // Shift-and-add multiply, reduced by the AES polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = 8'h00;
        aa  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ aa;
            end
            aa = {aa[6:0], 1'b0} ^ (aa[7] ? POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    // Squaring is linear over GF(2): spread bits to even positions, then reduce
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        logic [14:0] s;
        s = 15'h0000;
        for (int i = 0; i < 8; i++) begin
            s[2*i] = a[i];
        end
        for (int k = 14; k >= 8; k--) begin
            s = s ^ ({15{s[k]}} & ({6'd0, 1'b1, POLY_LOW} << (k - 8)));
        end
        return s[7:0];
    endfunction

    // Rotate a byte left by a constant amount (1..7)
    function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = b << n;
        hi = b >> (8 - n);
        return lo | hi;
    endfunction

    function automatic logic [7:0] fwd_affine(input logic [7:0] b);
        return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ FWD_CONST;
    endfunction

    function automatic logic [7:0] inv_affine(input logic [7:0] b);
        return rotl8(b, 1) ^ rotl8(b, 3) ^ rotl8(b, 6) ^ INV_CONST;
    endfunction

endpackage

[design/aes_sbox_forward_inverse.sv]
// AES forward / inverse S-box as a four-stage pipeline with per-stage flow control.
//
// Usage:
//   Input stream (s_axis_*): one byte in tdata[7:0], direction in tuser[0]
//   (0 = SubBytes, 1 = InvSubBytes). A transfer happens when tvalid and
//   tready are both high.
//   Output stream (m_axis_*): substituted byte in tdata[7:0].
//   Each byte passes four registered stages on its way to the output; while
//   the receiver holds m_axis_tready high, one byte can enter every cycle, so
//   sustained throughput is 1 byte/cycle. The field inverse is computed as
//   a^254 by an addition chain: stage 1 applies the inverse affine map for
//   InvSubBytes and forms a^3, stage 2 forms a^15 and a^14, stage 3 forms
//   a^254, and stage 4 applies the forward affine map for SubBytes only.
//   Each stage has its own valid bit and takes a new item whenever it is
//   empty or its downstream stage moves, so bubbles are squeezed out.
//   When the receiver holds m_axis_tready low, the output byte holds and
//   upstream stages fill; s_axis_tready drops only once all four are full.
//   Nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties all stages; the block keeps no
//   other state.
module aes_sbox_forward_inverse
    import aes_sb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_in
    input  logic [0:0] s_axis_tuser,   // [0] op
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] data_out
);

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    // Stage payloads
    logic       op1_reg, op2_reg, op3_reg;
    logic [7:0] b1_reg, a3_reg;
    logic [7:0] a15_reg, a14_reg;
    logic [7:0] inv_reg;
    logic [7:0] out_reg;

    // Stage advance: take new data when empty or when the next stage moves
    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    // Stage 1: inverse affine for InvSubBytes, then a^3
    logic [7:0] b1_next, a3_next;
    always_comb begin
        b1_next = (s_axis_tuser[0] == OP_INV) ? inv_affine(s_axis_tdata) : s_axis_tdata;
        a3_next = gf_mul(gf_sq(b1_next), b1_next);
    end

    // Stage 2: a^12 = (a^3)^4, a^15 = a^12 * a^3, a^14 = a^12 * a^2
    logic [7:0] a12_w, a15_next, a14_next;
    always_comb begin
        a12_w    = gf_sq(gf_sq(a3_reg));
        a15_next = gf_mul(a12_w, a3_reg);
        a14_next = gf_mul(a12_w, gf_sq(b1_reg));
    end

    // Stage 3: a^254 = (a^15)^16 * a^14
    logic [7:0] inv_next;
    always_comb begin
        inv_next = gf_mul(gf_sq(gf_sq(gf_sq(gf_sq(a15_reg)))), a14_reg);
    end

    // Stage 4: forward affine map unless inverse direction
    logic [7:0] out_next;
    always_comb begin
        out_next = (op3_reg == OP_INV) ? inv_reg : fwd_affine(inv_reg);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            op1_reg <= s_axis_tuser[0];
            b1_reg  <= b1_next;
            a3_reg  <= a3_next;
        end
        if (rdy2) begin
            op2_reg <= op1_reg;
            a15_reg <= a15_next;
            a14_reg <= a14_next;
        end
        if (rdy3) begin
            op3_reg <= op2_reg;
            inv_reg <= inv_next;
        end
        if (rdy4) begin
            out_reg <= out_next;
        end
    end

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = out_reg;

endmodule

[design/aes_sb_checker.sv]
// Port-level checker for the S-box pipeline, bound to the top level.
module aes_sb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled output transfer keeps its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // Reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // With an empty output stage the whole pipe can move, so input is ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

    // A pipe with a free-running output cannot back up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready && $past(m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while receiver always ready");

endmodule

bind aes_sbox_forward_inverse aes_sb_checker u_aes_sb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/tb_aes_sbox_forward_inverse.sv]
// Self-checking testbench for the AES forward/inverse byte substitution stream block.
`timescale 1ns / 1ps

module tb_aes_sbox_forward_inverse;
    import aes_sb_pkg::*;

    localparam int          RANDOM_PER_PHASE = 667;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES     = 10;
    localparam logic [7:0]  REDUCE_LOW       = 8'h1B;
    localparam logic [7:0]  AFFINE_ADD       = 8'h63;

    // One pending substitution: direction, input byte, expected output byte
    typedef struct packed {
        logic       op;
        logic [7:0] din;
        logic [7:0] dout;
    } sub_t;

    // Directed row: want is only used when known is set
    typedef struct packed {
        logic       op;
        logic [7:0] din;
        logic       known;
        logic [7:0] want;
    } dir_row_t;

    localparam int NUM_ROWS = 19;
    dir_row_t dir_rows [NUM_ROWS] = '{
        '{OP_FWD, 8'h00, 1'b1, 8'h63},   // zero maps to zero before the affine step
        '{OP_FWD, 8'h01, 1'b1, 8'h7C},
        '{OP_FWD, 8'hFF, 1'b1, 8'h16},
        '{OP_FWD, 8'h80, 1'b1, 8'hCD},
        '{OP_FWD, 8'h7F, 1'b1, 8'hD2},
        '{OP_FWD, 8'h53, 1'b1, 8'hED},
        '{OP_FWD, 8'h63, 1'b1, 8'hFB},
        '{OP_INV, 8'h63, 1'b1, 8'h00},   // inverse of the zero case
        '{OP_INV, 8'h00, 1'b1, 8'h52},
        '{OP_INV, 8'hFF, 1'b1, 8'h7D},
        '{OP_INV, 8'h7C, 1'b1, 8'h01},
        '{OP_INV, 8'h16, 1'b1, 8'hFF},
        '{OP_INV, 8'hED, 1'b1, 8'h53},
        '{OP_INV, 8'h80, 1'b1, 8'h3A},
        '{OP_INV, 8'h01, 1'b1, 8'h09},
        '{OP_FWD, 8'hAA, 1'b0, 8'h00},
        '{OP_FWD, 8'h55, 1'b0, 8'h00},
        '{OP_INV, 8'hAA, 1'b0, 8'h00},
        '{OP_INV, 8'h55, 1'b0, 8'h00}
    };

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_in
    logic [0:0] s_axis_tuser  = 1'b0;    // [0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] data_out

    // Predicted substitution tables, filled at time zero
    logic [7:0] fwd_lut [256];
    logic [7:0] inv_lut [256];

    sub_t       subs_pending [$];
    sub_t       got_sub;
    sub_t       new_sub;
    logic       row_known = 1'b0;
    logic [7:0] row_want  = 8'h00;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         errors = 0;
    int         fwd_count = 0;
    int         inv_count = 0;
    int         out_count = 0;
    int         quiet_cycles = 0;

    aes_sbox_forward_inverse dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // GF(2^8) product, walking the bits of a and doubling b
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] dbl;
        acc = 8'h00;
        dbl = b;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) begin
                acc ^= dbl;
            end
            dbl = {dbl[6:0], 1'b0} ^ (dbl[7] ? REDUCE_LOW : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbox_affine(input logic [7:0] b);
        return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                 ^ {b[3:0], b[7:4]} ^ AFFINE_ADD;
    endfunction

    // Forward table by brute-force field inverse; the inverse table is its inverse permutation
    initial begin
        logic [7:0] recip;
        for (int x = 0; x < 256; x++) begin
            recip = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (gf_times(x[7:0], y[7:0]) == 8'h01) begin
                    recip = y[7:0];
                end
            end
            fwd_lut[x] = sbox_affine(recip);
        end
        for (int x = 0; x < 256; x++) begin
            inv_lut[fwd_lut[x]] = x[7:0];
        end
    end

    function automatic logic [7:0] substitute(input logic op, input logic [7:0] din);
        return (op == OP_INV) ? inv_lut[din] : fwd_lut[din];
    endfunction

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Scoreboard: check outputs against the oldest prediction, record new inputs
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                out_count++;
                if (subs_pending.size() == 0) begin
                    errors++;
                    $display("%0t: output with nothing expected: expected none, actual %02h",
                             $time, m_axis_tdata);
                end else begin
                    got_sub = subs_pending.pop_front();
                    if (m_axis_tdata !== got_sub.dout) begin
                        errors++;
                        $display("%0t: data_out mismatch (op %0d, in %02h): %s %02h, %s %02h",
                                 $time, got_sub.op, got_sub.din, "expected",
                                 got_sub.dout, "actual", m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
                new_sub.op   = s_axis_tuser[0];
                new_sub.din  = s_axis_tdata;
                new_sub.dout = row_known ? row_want : substitute(s_axis_tuser[0], s_axis_tdata);
                subs_pending.push_back(new_sub);
                if (s_axis_tuser[0] == OP_INV) begin
                    inv_count++;
                end else begin
                    fwd_count++;
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Present one item, with random sender gaps, and hold it until the transfer
    task automatic send_sub(input logic op, input logic [7:0] din,
                            input logic known, input logic [7:0] want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = din;
        row_known     = known;
        row_want      = want;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Random items, leaning a little toward 00, FF and 63
    task automatic send_random(input int count);
        logic [7:0] din;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       din = 8'h00;
                1:       din = 8'hFF;
                2:       din = AFFINE_ADD;
                default: din = 8'($urandom_range(0, 255));
            endcase
            send_sub(1'($urandom_range(0, 1)), din, 1'b0, 8'h00);
        end
    endtask

    // Stimulus
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Sender idles less than receiver
        tx_idle_pct = 29;
        rx_idle_pct = 48;
        for (int r = 0; r < NUM_ROWS; r++) begin
            send_sub(dir_rows[r].op, dir_rows[r].din, dir_rows[r].known, dir_rows[r].want);
        end
        send_random(RANDOM_PER_PHASE);

        // Swapped: receiver idles less than sender
        tx_idle_pct = 48;
        rx_idle_pct = 29;
        send_random(RANDOM_PER_PHASE);

        // Full rate, no gaps either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(RANDOM_PER_PHASE);

        s_axis_tvalid = 1'b0;
        row_known     = 1'b0;
        while (subs_pending.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d substitutions (%0d forward, %0d inverse), %0d outputs checked",
                 fwd_count + inv_count, fwd_count, inv_count, out_count);
        $display("over three back-pressure phases; %0d mismatches", errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
